@@ hdl/v3n_pkg.sv @@
// Shared types and constants for the three-component vector normalizer.
package v3n_pkg;

  localparam int unsigned CompW  = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RemW   = 34;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned FracW  = 16;
  localparam int unsigned SqrtN  = 32;
  localparam int unsigned DivN   = 17;
  localparam logic [31:0] MinLenReset = 32'd1;
  localparam logic        RegMinLen   = 1'b0;

  // Raw input components, carried along to the end for pass-through and signs.
  typedef struct packed {
    logic [CompW-1:0] x;
    logic [CompW-1:0] y;
    logic [CompW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t            vec;
    logic [SumW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [31:0]     root;
  } sq_t;

  typedef struct packed {
    vec_t                  vec;
    logic [31:0]           len;
    logic                  skip;
    logic [2:0][31:0]      rem;
    logic [2:0][QuoW-1:0]  dvd;
    logic [2:0][QuoW-1:0]  quo;
  } dv_t;

endpackage

@@ hdl/v3n_sqrt_cell.sv @@
// One cell of the square root chain: settles one bit of the root.
module v3n_sqrt_cell
  import v3n_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  data_i,
  output logic valid_o,
  output sq_t  data_o
);

  logic        valid_q;
  sq_t         data_q, data_d;
  logic [35:0] shifted;
  logic [35:0] trial;

  always_comb begin
    shifted = {data_i.rem, data_i.rad[63:62]};
    trial   = {2'b00, data_i.root, 2'b01};
    data_d      = data_i;
    data_d.rad  = {data_i.rad[61:0], 2'b00};
    if (shifted >= trial) begin
      data_d.rem  = RemW'(shifted - trial);
      data_d.root = {data_i.root[30:0], 1'b1};
    end else begin
      data_d.rem  = RemW'(shifted);
      data_d.root = {data_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/v3n_div_cell.sv @@
// One cell of the divider chain: one quotient bit for each of the three components.
module v3n_div_cell
  import v3n_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  dv_t  data_i,
  output logic valid_o,
  output dv_t  data_o
);

  logic        valid_q;
  dv_t         data_q, data_d;
  logic [32:0] part [3];

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      part[i] = {data_i.rem[i], data_i.dvd[i][QuoW-1]};
      data_d.dvd[i] = {data_i.dvd[i][QuoW-2:0], 1'b0};
      if (part[i] >= {1'b0, data_i.len}) begin
        data_d.rem[i] = 32'(part[i] - {1'b0, data_i.len});
        data_d.quo[i] = {data_i.quo[i][QuoW-2:0], 1'b1};
      end else begin
        data_d.rem[i] = part[i][31:0];
        data_d.quo[i] = {data_i.quo[i][QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ hdl/vector3_normalize.sv @@
// Top level of the vector normalizer: squares, root chain, divider chain, output register.
//
//   channel | direction | handshake                       | payload
//   in      | in        | in_valid_i / in_ready_o         | in_x_i, in_y_i, in_z_i
//   out     | out       | out_valid_o / out_ready_i       | out_x_o .. magnitude_o, skipped_o
//   cfg     | in        | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; each item passes these registers in order:
// two for the squares and their sum, 32 root cells, 17 divider cells, one for sign and output.
// All stages move together; a stalled output holds the whole chain and drops in_ready_o.
// Reset clears every valid bit and sets min_length to 1.
module vector3_normalize
  import v3n_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] magnitude_o,
  output logic        skipped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        en;
  logic [31:0] min_len_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMinLen) ? min_len_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegMinLen) begin
      min_len_q <= pwdata;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  // Squares, then their sum.
  logic        v1_q, v2_q;
  vec_t        vec1_q, vec2_q;
  logic [63:0] sqx_q, sqy_q, sqz_q, sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vec1_q <= '{x: in_x_i, y: in_y_i, z: in_z_i};
      sqx_q  <= mag32(in_x_i) * mag32(in_x_i);
      sqy_q  <= mag32(in_y_i) * mag32(in_y_i);
      sqz_q  <= mag32(in_z_i) * mag32(in_z_i);
      vec2_q <= vec1_q;
      sum_q  <= sqx_q + sqy_q + sqz_q;
    end
  end

  // Square root chain.
  logic sq_v [SqrtN+1];
  sq_t  sq_d [SqrtN+1];

  assign sq_v[0] = v2_q;
  assign sq_d[0] = '{vec: vec2_q, rad: sum_q, rem: '0, root: '0};

  for (genvar g = 0; g < SqrtN; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sq_v[g]), .data_i(sq_d[g]),
      .valid_o(sq_v[g+1]), .data_o(sq_d[g+1])
    );
  end

  // Divider chain; the quotient never exceeds 2^16 since each magnitude is at most the length.
  logic        dv_v [DivN+1];
  dv_t         dv_d [DivN+1];
  logic [31:0] len;
  logic [31:0] m [3];

  always_comb begin
    len  = sq_d[SqrtN].root;
    m[0] = mag32(sq_d[SqrtN].vec.x);
    m[1] = mag32(sq_d[SqrtN].vec.y);
    m[2] = mag32(sq_d[SqrtN].vec.z);
    dv_d[0].vec  = sq_d[SqrtN].vec;
    dv_d[0].len  = len;
    dv_d[0].skip = (len < min_len_q) || (len == 32'd0);
    dv_d[0].quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].rem[2-i] = {1'b0, m[i][31:1]};
      dv_d[0].dvd[2-i] = {m[i][0], 16'd0};
    end
  end
  assign dv_v[0] = sq_v[SqrtN];

  for (genvar g = 0; g < DivN; g++) begin : g_div
    v3n_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv_v[g]), .data_i(dv_d[g]),
      .valid_o(dv_v[g+1]), .data_o(dv_d[g+1])
    );
  end

  // Sign and pass-through selection into the output register.
  dv_t         fin;
  logic [31:0] res [3];
  logic [31:0] raw [3];

  always_comb begin
    fin    = dv_d[DivN];
    raw[0] = fin.vec.x;
    raw[1] = fin.vec.y;
    raw[2] = fin.vec.z;
    for (int i = 0; i < 3; i++) begin
      res[i] = raw[i][31] ? 32'(-{15'd0, fin.quo[2-i]}) : {15'd0, fin.quo[2-i]};
      if (fin.skip) begin
        res[i] = raw[i];
      end
    end
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v[DivN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_o     <= res[0];
      out_y_o     <= res[1];
      out_z_o     <= res[2];
      magnitude_o <= fin.len;
      skipped_o   <= fin.skip;
    end
  end

  assign out_valid_o = out_valid_q;

  a_zero_len_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && magnitude_o == 32'd0 |-> skipped_o)
    else $error("zero length item was divided");

  a_stall_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o))
    else $error("output changed under stall");

  a_unit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !skipped_o |-> (out_x_o[31] ? (-out_x_o) : out_x_o) <= 32'h0001_0000)
    else $error("unit component above one");

endmodule

@@ test/tb_vector3_normalize.sv @@
// Self-checking testbench for the three-component vector normalizer.
module tb_vector3_normalize;
  import v3n_pkg::*;

  localparam int Latency = 52;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] mag;
    logic        skip;
  } norm_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] in_x_i = '0;
  logic [31:0] in_y_i = '0;
  logic [31:0] in_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o, magnitude_o;
  logic        skipped_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  norm_res_t   expected_q[$];
  logic [31:0] min_len_cfg;
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          rx_stall_long = 1'b0;

  vector3_normalize u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [31:0] isqrt(logic [63:0] n);
    logic [31:0] root;
    logic [63:0] sq;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      sq = {32'd0, root | (32'd1 << b)} * {32'd0, root | (32'd1 << b)};
      if (sq <= n) root = root | (32'd1 << b);
    end
    return root;
  endfunction

  function automatic logic [31:0] unit_of(logic [31:0] c, logic [31:0] len);
    logic [63:0] m, q;
    m = c[31] ? 64'(-$signed(c)) : 64'(c);
    m = m & 64'hFFFF_FFFF;
    q = (m << 16) / {32'd0, len};
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic norm_res_t normalize(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    norm_res_t r;
    logic [63:0] mx, my, mz;
    mx = x[31] ? (64'd0 - {32'hFFFF_FFFF, x}) : {32'd0, x};
    my = y[31] ? (64'd0 - {32'hFFFF_FFFF, y}) : {32'd0, y};
    mz = z[31] ? (64'd0 - {32'hFFFF_FFFF, z}) : {32'd0, z};
    r.mag = isqrt(mx * mx + my * my + mz * mz);
    if (r.mag < min_len_cfg || r.mag == 0) begin
      r.x = x; r.y = y; r.z = z; r.skip = 1'b1;
    end else begin
      r.x = unit_of(x, r.mag); r.y = unit_of(y, r.mag); r.z = unit_of(z, r.mag);
      r.skip = 1'b0;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Valid stays high between back-to-back items and drops only for a gap.
  task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_x_i <= x; in_y_i <= y; in_z_i <= z;
    expected_q.push_back(normalize(x, y, z));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd4 * RegMinLen) min_len_cfg = data;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8'hFF)) - 128);
      2: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 32'h7FF_FFFF)) - 32'h400_0000);
    endcase
  endfunction

  // Directed extremes: zero, unit axes, full-scale and minimum values.
  task automatic test_directed();
    send_vector(0, 0, 0);
    send_vector(32'h0001_0000, 0, 0);
    send_vector(0, 32'hFFFF_0000, 0);
    send_vector(0, 0, 32'h0000_0001);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 0, 0);
    send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_vector(32'h0003_0000, 32'h0004_0000, 0);
    send_vector(32'h0000_0100, 32'h0000_0100, 32'h0000_0100);
    send_vector(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0001);
  endtask

  // Zero threshold: only the zero vector is skipped.
  task automatic test_zero_threshold();
    write_reg(3'd4 * RegMinLen, 32'd0);
    send_vector(0, 0, 0);
    send_vector(0, 0, 32'h0000_0001);
    send_vector(32'hFFFF_FFFF, 0, 0);
    drain();
  endtask

  // Largest threshold: every vector passes through.
  task automatic test_max_threshold();
    write_reg(3'd4 * RegMinLen, 32'hFFFF_FFFF);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 20; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
    drain();
  endtask

  // A write to an unused address must leave the threshold alone.
  task automatic test_unused_address();
    write_reg(3'd4 * RegMinLen, 32'h0001_0000);
    write_reg(3'd4, 32'hFFFF_FFFF);
    send_vector(32'h0000_8000, 0, 0);
    send_vector(32'h0001_0000, 0, 0);
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_reg(3'd4 * RegMinLen, 32'd1);
        1: write_reg(3'd4 * RegMinLen, 32'h0000_0100);
        2: write_reg(3'd4 * RegMinLen, $urandom_range(0, 32'h0200_0000));
        default: write_reg(3'd4 * RegMinLen, 32'h0100_0000);
      endcase
      for (int i = 0; i < 120; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
      drain();
    end
  endtask

  // Receiver: random stalls, with long phases of higher readiness.
  always @(posedge clk_i) begin
    if (rx_stall_long) out_ready_i <= ($urandom_range(0, 99) < 90);
    else if ($urandom_range(0, 99) < 3) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(0, 99) < 70);
    if ($urandom_range(0, 299) == 0) rx_stall_long <= !rx_stall_long;
  end

  always @(posedge clk_i) begin
    norm_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item x=%h", out_x_o);
      end else begin
        want = expected_q.pop_front();
        if (want.x !== out_x_o || want.y !== out_y_o || want.z !== out_z_o ||
            want.mag !== magnitude_o || want.skip !== skipped_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h mag %h skip %b, got %h %h %h mag %h skip %b",
                     want.x, want.y, want.z, want.mag, want.skip,
                     out_x_o, out_y_o, out_z_o, magnitude_o, skipped_o);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    min_len_cfg = MinLenReset;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_zero_threshold();
    test_max_threshold();
    test_unused_address();
    test_random();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
